[hw/rtl/alt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alt_pkg: shared types and constants of the assembly line tokenizer
// Token kinds, the character codes the classifier looks for and the bundle
// that carries the results of one input item from front to back.
// ----------------------------------------------------------------------------
package alt_pkg;

	// kind of one result token
	typedef enum logic [1:0] {
		KIND_CHAR     = 2'd0,
		KIND_WORD_END = 2'd1,
		KIND_LINE_END = 2'd2
	} kind_t;

	// input item kinds carried in tuser
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_END  = 1'b1;

	// character codes
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_COMMA   = 8'h2C;

	// up to three results of one input item, slot 0 goes out first
	typedef struct packed {
		logic [1:0]      count;
		kind_t [2:0]     kinds;
		logic [7:0]      ch;
	} bundle_t;

endpackage
`default_nettype wire

[hw/rtl/alt_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alt_front: character classifier
// Accepts one item a cycle while the queue is not full, keeps the string,
// comment, word and line flags, and bundles up to three tokens per item.
// ----------------------------------------------------------------------------
module alt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_action,
	input  logic [7:0]        in_ch,
	output logic              in_ready,
	input  logic              queue_full,
	output logic              push,
	output alt_pkg::bundle_t  push_data
);
	import alt_pkg::*;

	logic in_string_q, in_comment_q, word_open_q, line_open_q;
	logic str_d, cmt_d, wo_d, lo_d;
	logic lazy;
	logic special;
	logic [1:0] n;
	logic accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && !queue_full;

	assign special = (in_ch == CH_LBRACK) || (in_ch == CH_RBRACK) ||
		(in_ch == CH_PLUS) || (in_ch == CH_MINUS) ||
		(in_ch == CH_COLON) || (in_ch == CH_COMMA);

	// classify the item and collect its tokens in order
	always_comb begin
		str_d = in_string_q;
		cmt_d = in_comment_q;
		wo_d  = word_open_q;
		lo_d  = line_open_q;
		lazy  = 1'b0;
		n     = 2'd0;
		push_data.kinds = '{KIND_CHAR, KIND_CHAR, KIND_CHAR};
		push_data.ch    = in_ch;
		if (in_action == ACT_END || in_ch == CH_NEWLINE) begin
			if (in_action == ACT_PUSH) begin
				str_d = 1'b0;
				cmt_d = 1'b0;
			end
			if (wo_d) begin
				push_data.kinds[n] = KIND_WORD_END;
				n    = n + 2'd1;
				wo_d = 1'b0;
				lo_d = 1'b1;
			end
			if (lo_d) begin
				push_data.kinds[n] = KIND_LINE_END;
				n    = n + 2'd1;
				lo_d = 1'b0;
			end
		end else if (!in_comment_q) begin
			if (!in_string_q && (in_ch == CH_SPACE || in_ch == CH_TAB ||
					in_ch == CH_SEMI)) begin
				// separator or comment start: close the word, drop the char
				if (wo_d) begin
					push_data.kinds[n] = KIND_WORD_END;
					n    = n + 2'd1;
					wo_d = 1'b0;
					lo_d = 1'b1;
				end
				if (in_ch == CH_SEMI)
					cmt_d = 1'b1;
			end else begin
				if (in_ch == CH_QUOTE) begin
					lazy  = in_string_q;
					str_d = !in_string_q;
				end else if (special && !in_string_q) begin
					lazy = 1'b1;
					if (wo_d) begin
						push_data.kinds[n] = KIND_WORD_END;
						n    = n + 2'd1;
						wo_d = 1'b0;
						lo_d = 1'b1;
					end
				end
				// the character itself
				push_data.kinds[n] = KIND_CHAR;
				n    = n + 2'd1;
				wo_d = 1'b1;
				if (lazy) begin
					push_data.kinds[n] = KIND_WORD_END;
					n    = n + 2'd1;
					wo_d = 1'b0;
					lo_d = 1'b1;
				end
			end
		end
		push_data.count = n;
	end

	assign push = accept && (n != 2'd0);

	// tokenizer flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_string_q  <= 1'b0;
			in_comment_q <= 1'b0;
			word_open_q  <= 1'b0;
			line_open_q  <= 1'b0;
		end else if (accept) begin
			in_string_q  <= str_d;
			in_comment_q <= cmt_d;
			word_open_q  <= wo_d;
			line_open_q  <= lo_d;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/alt_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alt_queue: bundle queue
// Short first-in first-out store of token bundles between classifier and
// serialiser, so that either side may stall on its own.
// ----------------------------------------------------------------------------
module alt_queue #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  alt_pkg::bundle_t  push_data,
	output logic              full,
	input  logic              pop,
	output alt_pkg::bundle_t  head,
	output logic              empty
);
	import alt_pkg::*;

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	bundle_t         entry_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = count_q == CntW'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[hw/rtl/alt_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alt_back: token serialiser
// Walks the head bundle's slots into the output register one per cycle while
// it is not stalled, and releases the bundle once its final token is loaded.
// ----------------------------------------------------------------------------
module alt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  alt_pkg::bundle_t  head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        out_kind,
	output logic [7:0]        out_char,
	output logic              out_last
);
	import alt_pkg::*;

	logic [1:0] idx_q;
	logic       load;
	logic       slot_last;
	kind_t      slot_kind;
	logic       valid_q;
	kind_t      kind_q;
	logic [7:0] char_q;
	logic       last_q;

	assign slot_kind = head.kinds[idx_q];
	assign slot_last = idx_q == (head.count - 2'd1);
	assign load      = !empty && (!valid_q || out_ready);
	assign pop       = load && slot_last;

	// slot index within the head bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (load)
			idx_q <= slot_last ? 2'd0 : idx_q + 2'd1;
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= slot_kind;
			char_q <= (slot_kind == KIND_CHAR) ? head.ch : 8'd0;
			last_q <= slot_last;
		end
	end

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

endmodule
`default_nettype wire

[hw/rtl/assembly_line_tokenizer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// assembly_line_tokenizer: assembly source word and line splitter
// Takes source characters and emits word characters, word-end and line-end
// tokens.
// ----------------------------------------------------------------------------
// Usage
//   slave side: one transfer per character; s_tuser[0] = 1 marks end of input
//   (flush word and line), s_tdata[7:0] holds the character.
//   master side: one transfer per token; m_tuser[1:0] is the token kind
//   (character, word end, line end), m_tdata[7:0] the character or zero,
//   m_tlast marks the final token caused by one input character.
//   With the queue empty a character's first token is written to the bundle
//   queue and then loaded into the output register, which presents it.
//   Throughput: one input transfer per cycle while the queue is not full
//   and one output transfer per cycle while m_tready is high; an item that
//   yields two or three tokens holds the output for one transfer per token,
//   and the bundle queue of QUEUE_DEPTH entries absorbs them.
//   Items that yield no token (comment text, blanks with no word open) use no
//   queue entry.
//   When the receiver stalls the output register holds and the queue fills;
//   s_tready falls only when the queue is full.
//   Reset clears all mode flags, empties the queue and drops the output.
// ----------------------------------------------------------------------------
module assembly_line_tokenizer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] ch
	input  logic [0:0] s_tuser,   // [0] action
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] char_value
	output logic [1:0] m_tuser,   // [1:0] token_kind
	output logic       m_tlast
);
	import alt_pkg::*;

	logic    push, pop, full, empty;
	bundle_t push_data, head;

	// classifier
	alt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_action  (s_tuser[0]),
		.in_ch      (s_tdata),
		.in_ready   (s_tready),
		.queue_full (full),
		.push       (push),
		.push_data  (push_data)
	);

	// bundle queue
	alt_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	// serialiser and output register
	alt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_char  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the assembly line tokenizer
// Streams source characters and end-of-input items into the block. The bench
// keeps its own copy of the string, comment, word and line flags, and works
// out the tokens that each transfer should give. Every output transfer is
// checked against the oldest expected token. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
	import alt_pkg::*;

	// one source item as it is queued for the sender
	typedef struct packed {
		logic       action;
		logic [7:0] ch;
	} src_item_t;

	// one expected token
	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		logic       last;
	} token_t;

	localparam int IDLE_LIMIT   = 1000;
	localparam int RANDOM_ITEMS = 225;
	localparam int TAIL_CYCLES  = 20;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic [0:0] s_tuser = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;

	src_item_t pending_items[$];
	token_t    expected_tokens[$];

	// mode flags of the bench's own tokenizer
	logic ln_in_string  = 1'b0;
	logic ln_in_comment = 1'b0;
	logic ln_word_open  = 1'b0;
	logic ln_line_open  = 1'b0;
	token_t step_toks[3];
	int     step_n;

	logic in_fire = 1'b0;
	logic out_fire = 1'b0;
	int   send_gap = 0;
	int   send_calm = 0;
	int   recv_stall = 0;
	int   recv_calm = 0;
	int   idle_cycles = 0;
	int   fail_count = 0;
	int   items_in = 0;
	int   tokens_out = 0;
	int   word_ends = 0;
	int   line_ends = 0;
	int   random_items = 0;
	bit   counting = 1'b1;

	assembly_line_tokenizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// clock, 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// gap length: mostly none or short, a few long, with quiet stretches
	function automatic int pick_gap(inout int calm_left);
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 99) < 4) begin
			calm_left = $urandom_range(15, 40);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// token builders for one input item
	task automatic emit_tok(input kind_t kind, input logic [7:0] value);
		step_toks[step_n] = '{kind: kind, value: value, last: 1'b0};
		step_n++;
	endtask

	task automatic close_word_tok();
		if (ln_word_open) begin
			emit_tok(KIND_WORD_END, 8'h00);
			ln_word_open = 1'b0;
			ln_line_open = 1'b1;
		end
	endtask

	task automatic close_line_tok();
		if (ln_line_open) begin
			emit_tok(KIND_LINE_END, 8'h00);
			ln_line_open = 1'b0;
		end
	endtask

	// tokens caused by one accepted source item
	task automatic tokenize_item(input logic action, input logic [7:0] c);
		bit drop;
		bit split_after;
		bit special;
		step_n = 0;
		drop = 1'b0;
		split_after = 1'b0;
		special = 1'b0;
		if (action == ACT_END) begin
			close_word_tok();
			close_line_tok();
		end else if (c == CH_NEWLINE) begin
			ln_in_string = 1'b0;
			ln_in_comment = 1'b0;
			close_word_tok();
			close_line_tok();
		end else if (!ln_in_comment) begin
			case (c)
				CH_LBRACK, CH_RBRACK, CH_PLUS, CH_MINUS, CH_COLON, CH_COMMA:
					special = 1'b1;
				default: ;
			endcase
			if (c == CH_SPACE || c == CH_TAB) begin
				if (!ln_in_string) begin
					close_word_tok();
					drop = 1'b1;
				end
			end else if (c == CH_QUOTE) begin
				// a closing quote ends its word
				split_after = ln_in_string;
				ln_in_string = !ln_in_string;
			end else if (c == CH_SEMI) begin
				if (!ln_in_string) begin
					close_word_tok();
					ln_in_comment = 1'b1;
					drop = 1'b1;
				end
			end else if (special && !ln_in_string) begin
				close_word_tok();
				split_after = 1'b1;
			end
			if (!drop) begin
				emit_tok(KIND_CHAR, c);
				ln_word_open = 1'b1;
				if (split_after)
					close_word_tok();
			end
		end
		if (step_n > 0)
			step_toks[step_n - 1].last = 1'b1;
		for (int i = 0; i < step_n; i++)
			expected_tokens.push_back(step_toks[i]);
	endtask

	// sender: one item per transfer, held until taken
	always @(negedge clk) begin : sender
		src_item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !in_fire) begin
			// hold the current item
		end else if (send_gap > 0) begin
			send_gap--;
			s_tvalid <= 1'b0;
		end else if (pending_items.size() > 0) begin
			it = pending_items.pop_front();
			s_tdata  <= it.ch;
			s_tuser  <= it.action;
			s_tvalid <= 1'b1;
			send_gap = pick_gap(send_calm);
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// receiver: random stalls after each transfer
	always @(negedge clk) begin : receiver
		logic nxt;
		int g;
		nxt = 1'b1;
		if (!arst_n) begin
			nxt = 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			nxt = 1'b0;
		end else if (out_fire) begin
			g = pick_gap(recv_calm);
			if (g > 0) begin
				nxt = 1'b0;
				recv_stall = g - 1;
			end
		end
		m_tready <= nxt;
	end

	// monitor: predict on input transfers, check on output transfers
	always @(posedge clk) begin : monitor
		token_t want;
		in_fire  <= arst_n && s_tvalid && s_tready;
		out_fire <= arst_n && m_tvalid && m_tready;
		if (arst_n && s_tvalid && s_tready) begin
			items_in++;
			tokenize_item(s_tuser[0], s_tdata);
		end
		if (arst_n && m_tvalid && m_tready) begin
			tokens_out++;
			if (m_tuser == KIND_WORD_END)
				word_ends++;
			if (m_tuser == KIND_LINE_END)
				line_ends++;
			if (expected_tokens.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("[%0t] unexpected token: kind %0d char %02h last %0b",
						$realtime, m_tuser, m_tdata, m_tlast);
			end else begin
				want = expected_tokens.pop_front();
				if (m_tuser !== want.kind || m_tdata !== want.value
						|| m_tlast !== want.last) begin
					fail_count++;
					if (fail_count <= 10)
						$display("[%0t] token mismatch: expected kind %0d char %02h last %0b, got kind %0d char %02h last %0b",
							$realtime, want.kind, want.value, want.last,
							m_tuser, m_tdata, m_tlast);
				end
			end
		end
	end

	// watchdog: cycles with work outstanding but no transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else if (pending_items.size() > 0 || expected_tokens.size() > 0
				|| s_tvalid) begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: %0d cycles without a transfer, %0d tokens outstanding",
					idle_cycles, expected_tokens.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// stimulus helpers
	task automatic put(input logic action, input logic [7:0] c);
		pending_items.push_back('{action: action, ch: c});
		if (counting)
			random_items++;
	endtask

	function automatic logic [7:0] word_byte();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return 8'(8'h61 + $urandom_range(0, 25));
		if (r < 15)
			return 8'(8'h30 + $urandom_range(0, 9));
		if (r == 15)
			return 8'h5F;
		if (r == 16)
			return 8'h2E;
		if (r == 17)
			return 8'h23;
		return 8'(8'h80 + $urandom_range(0, 127));
	endfunction

	task automatic put_word();
		repeat ($urandom_range(1, 5))
			put(ACT_PUSH, word_byte());
	endtask

	task automatic put_blank();
		repeat ($urandom_range(1, 2))
			put(ACT_PUSH, $urandom_range(0, 1) ? CH_SPACE : CH_TAB);
	endtask

	// quoted text, any byte but newline and quote inside
	task automatic put_string(input bit unterminated);
		logic [7:0] b;
		put(ACT_PUSH, CH_QUOTE);
		repeat ($urandom_range(0, 6)) begin
			do
				b = 8'($urandom_range(0, 255));
			while (b == CH_NEWLINE || b == CH_QUOTE);
			put(ACT_PUSH, b);
		end
		if (!unterminated)
			put(ACT_PUSH, CH_QUOTE);
	endtask

	// comment from a semicolon, any byte but newline after it
	task automatic put_comment();
		logic [7:0] b;
		put(ACT_PUSH, CH_SEMI);
		repeat ($urandom_range(0, 8)) begin
			do
				b = 8'($urandom_range(0, 255));
			while (b == CH_NEWLINE);
			put(ACT_PUSH, b);
		end
	endtask

	// one source line: label, mnemonic, operands and comment, an empty line, or noise
	task automatic gen_line();
		int shape;
		int nops;
		shape = $urandom_range(0, 19);
		if (shape < 2) begin
			repeat ($urandom_range(1, 8))
				put(ACT_PUSH, 8'($urandom_range(0, 255)));
			return;
		end
		if (shape == 5) begin
			put(ACT_PUSH, CH_NEWLINE);
			return;
		end
		if ($urandom_range(0, 3) == 0) begin
			put_word();
			put(ACT_PUSH, CH_COLON);
		end
		if ($urandom_range(0, 1))
			put_blank();
		put_word();
		nops = $urandom_range(0, 3);
		for (int k = 0; k < nops; k++) begin
			if (k > 0)
				put(ACT_PUSH, CH_COMMA);
			if ($urandom_range(0, 1))
				put_blank();
			case ($urandom_range(0, 3))
				0: put_word();
				1: begin
					if ($urandom_range(0, 1))
						put(ACT_PUSH, CH_MINUS);
					put_word();
				end
				2: begin
					put(ACT_PUSH, CH_LBRACK);
					put_word();
					put(ACT_PUSH, $urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
					put_word();
					put(ACT_PUSH, CH_RBRACK);
				end
				default: put_string(shape == 2);
			endcase
		end
		if ($urandom_range(0, 3) == 0)
			put_comment();
		if (shape == 3)
			put(ACT_END, 8'($urandom_range(0, 255)));
		else
			put(ACT_PUSH, CH_NEWLINE);
	endtask

	// directed items, random lines, then drain and report
	initial begin
		counting = 1'b0;
		put(ACT_PUSH, 8'h00);
		put(ACT_PUSH, 8'hFF);
		put(ACT_PUSH, CH_TAB);
		put(ACT_PUSH, CH_SPACE);
		put(ACT_PUSH, CH_QUOTE);
		put(ACT_PUSH, CH_SPACE);
		put(ACT_PUSH, CH_SEMI);
		put(ACT_PUSH, CH_LBRACK);
		put(ACT_PUSH, CH_QUOTE);
		put(ACT_PUSH, CH_LBRACK);
		put(ACT_PUSH, 8'h6D);
		put(ACT_PUSH, CH_RBRACK);
		put(ACT_PUSH, CH_PLUS);
		put(ACT_PUSH, CH_MINUS);
		put(ACT_PUSH, CH_COLON);
		put(ACT_PUSH, CH_COMMA);
		put(ACT_PUSH, CH_SEMI);
		put(ACT_PUSH, 8'h7A);
		put(ACT_PUSH, CH_QUOTE);
		put(ACT_PUSH, CH_NEWLINE);
		put(ACT_PUSH, CH_QUOTE);
		put(ACT_END, 8'hA5);
		put(ACT_PUSH, 8'h71);
		put(ACT_PUSH, CH_NEWLINE);
		put(ACT_END, 8'h5A);
		counting = 1'b1;
		while (random_items < RANDOM_ITEMS)
			gen_line();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d source transfers and %0d tokens (%0d word ends, %0d line ends)",
			items_in, tokens_out, word_ends, line_ends);
		$display("mismatches: %0d, tokens still outstanding: %0d",
			fail_count, expected_tokens.size());
		if (fail_count == 0 && expected_tokens.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
